[rtl/assert_macros.svh]
// Assertion macros shared by the reachability RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/grd_pkg.sv]
// Shared types and constants for the graph reachability block.
// No dependencies; used by grd_ctrl, grd_datapath and graph_reachability_dfs.
package grd_pkg;

    localparam int NUM_VERTICES_DEF = 64;
    localparam int VERTEX_W         = 6;
    localparam int COUNT_W          = 7;
    localparam int MASK_W           = 64;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    // register index carried in paddr[2]
    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

    typedef enum logic [1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_TRAVERSE = 2'd1,
        CMD_CLEAR    = 2'd2
    } cmd_e;

    typedef enum logic [1:0] {
        SEL_SRC  = 2'd0,
        SEL_DST  = 2'd1,
        SEL_PICK = 2'd2
    } addr_sel_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EDGE_RD_SRC,
        ST_EDGE_WR_SRC,
        ST_EDGE_RD_DST,
        ST_EDGE_WR_DST,
        ST_WALK_ISSUE,
        ST_WALK_MERGE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic      capture;
        logic      clear_rows;
        logic      rd_en;
        logic      wr_en;
        addr_sel_e addr_sel;
        logic      walk_init;
        logic      walk_issue;
        logic      walk_merge;
        logic      load_result;
    } dp_cmd_t;

    typedef struct packed {
        cmd_e cmd_code;
        logic item_bad;
        logic pending_empty;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/graph_reachability_dfs.sv]
// A traverse expands each reached vertex in turn (row read, then merge) before its result; a bad vertex
// gives a bad-vertex result straight after decode; a valid add edge and a clear give no result.
// Throughput: one item at a time, s_tready high only while idle; a traverse holds the input
// until its walk is done and a bad item until decode, and either then waits on m_tready for its result.
// Reset (aresetn, synchronous, active low) empties the matrix through per-row valid bits,
// clears the visited mask and the result valid flag, and sets vertex_count to 64. No clearing pass.
module graph_reachability_dfs #(
    parameter int NUM_VERTICES = grd_pkg::NUM_VERTICES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // src_vertex[5:0], dest_vertex[11:6],
                                                        // root_vertex[17:12], zero pad
    input  logic [1:0]                       s_tuser,   // cmd[1:0]
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [71:0]                      m_tdata,   // visited_mask[63:0],
                                                        // reached_count[70:64], zero pad
    output logic [0:0]                       m_tuser,   // bad_vertex[0]
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [grd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [grd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [grd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    grd_pkg::dp_cmd_t             cmd;
    grd_pkg::dp_status_t          status;

    logic [grd_pkg::COUNT_W-1:0]  vertex_count_reg;
    logic [grd_pkg::COUNT_W-1:0]  n_eff;
    logic                         reg_hit;

    logic [grd_pkg::MASK_W-1:0]   out_mask;
    logic [grd_pkg::COUNT_W-1:0]  out_count;
    logic                         out_bad;

    // ---- register file: one register, vertex_count at byte address 0 ----
    assign pready  = 1'b1;
    assign reg_hit = (paddr[grd_pkg::APB_ADDR_W-1:2] == grd_pkg::REG_VERTEX_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= grd_pkg::VERTEX_COUNT_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            vertex_count_reg <= pwdata[grd_pkg::COUNT_W-1:0];
        end
    end

    assign prdata = reg_hit ? grd_pkg::APB_DATA_W'(vertex_count_reg) : '0;

    // stored value is kept as written; the count in use is clamped to 1..NUM_VERTICES
    always_comb begin
        if (vertex_count_reg == '0) begin
            n_eff = grd_pkg::COUNT_W'(1);
        end else if (vertex_count_reg > grd_pkg::COUNT_W'(NUM_VERTICES)) begin
            n_eff = grd_pkg::COUNT_W'(NUM_VERTICES);
        end else begin
            n_eff = vertex_count_reg;
        end
    end

    // ---- controller and datapath ----
    grd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    grd_datapath #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .n_eff     (n_eff),
        .in_cmd    (s_tuser),
        .in_src    (s_tdata[5:0]),
        .in_dst    (s_tdata[11:6]),
        .in_start  (s_tdata[17:12]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_mask  (out_mask),
        .out_count (out_count),
        .out_bad   (out_bad)
    );

    // ---- result packing ----
    assign m_tdata = {1'b0, out_count, out_mask};
    assign m_tuser = out_bad;

endmodule

[rtl/grd_ctrl.sv]
// Sequencer for the reachability block: decodes items, steps edge writes and the walk.
// Depends on grd_pkg; drives grd_datapath through dp_cmd_t.
module grd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  grd_pkg::dp_status_t status,
    output grd_pkg::dp_cmd_t    cmd
);

    grd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= grd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        cmd             = '0;
        cmd.addr_sel    = grd_pkg::SEL_SRC;
        unique case (state_reg)
            grd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = grd_pkg::ST_DECODE;
                end
            end
            grd_pkg::ST_DECODE: begin
                unique case (status.cmd_code)
                    grd_pkg::CMD_ADD_EDGE: begin
                        state_next = status.item_bad ? grd_pkg::ST_RESULT
                                                     : grd_pkg::ST_EDGE_RD_SRC;
                    end
                    grd_pkg::CMD_TRAVERSE: begin
                        if (status.item_bad) begin
                            state_next = grd_pkg::ST_RESULT;
                        end else begin
                            cmd.walk_init = 1'b1;
                            state_next    = grd_pkg::ST_WALK_ISSUE;
                        end
                    end
                    grd_pkg::CMD_CLEAR: begin
                        cmd.clear_rows = 1'b1;
                        state_next     = grd_pkg::ST_IDLE;
                    end
                    default: begin
                        state_next = grd_pkg::ST_IDLE;
                    end
                endcase
            end
            grd_pkg::ST_EDGE_RD_SRC: begin
                cmd.rd_en  = 1'b1;
                state_next = grd_pkg::ST_EDGE_WR_SRC;
            end
            grd_pkg::ST_EDGE_WR_SRC: begin
                cmd.wr_en  = 1'b1;
                state_next = grd_pkg::ST_EDGE_RD_DST;
            end
            grd_pkg::ST_EDGE_RD_DST: begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = grd_pkg::SEL_DST;
                state_next   = grd_pkg::ST_EDGE_WR_DST;
            end
            grd_pkg::ST_EDGE_WR_DST: begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = grd_pkg::SEL_DST;
                state_next   = grd_pkg::ST_IDLE;
            end
            grd_pkg::ST_WALK_ISSUE: begin
                if (status.pending_empty) begin
                    state_next = grd_pkg::ST_RESULT;
                end else begin
                    cmd.walk_issue = 1'b1;
                    cmd.rd_en      = 1'b1;
                    cmd.addr_sel   = grd_pkg::SEL_PICK;
                    state_next     = grd_pkg::ST_WALK_MERGE;
                end
            end
            grd_pkg::ST_WALK_MERGE: begin
                cmd.walk_merge = 1'b1;
                state_next     = grd_pkg::ST_WALK_ISSUE;
            end
            grd_pkg::ST_RESULT: begin
                if (status.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = grd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = grd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/grd_datapath.sv]
// Datapath: adjacency row memory, visited/pending masks, walk counter, result register.
// Depends on grd_pkg and assert_macros.svh; commanded by grd_ctrl.
`include "assert_macros.svh"

module grd_datapath #(
    parameter int NUM_VERTICES = grd_pkg::NUM_VERTICES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  grd_pkg::dp_cmd_t                cmd,
    output grd_pkg::dp_status_t             status,
    input  logic [grd_pkg::COUNT_W-1:0]     n_eff,
    input  logic [1:0]                      in_cmd,
    input  logic [grd_pkg::VERTEX_W-1:0]    in_src,
    input  logic [grd_pkg::VERTEX_W-1:0]    in_dst,
    input  logic [grd_pkg::VERTEX_W-1:0]    in_start,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [grd_pkg::MASK_W-1:0]      out_mask,
    output logic [grd_pkg::COUNT_W-1:0]     out_count,
    output logic                            out_bad
);

    localparam int VIDX_W = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;

    // lowest set bit of a mask
    function automatic logic [VIDX_W-1:0] lowest_set(input logic [NUM_VERTICES-1:0] m);
        logic [VIDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_VERTICES - 1; i >= 0; i--) begin
            if (m[i]) idx = VIDX_W'(i);
        end
        return idx;
    endfunction

    // captured item
    grd_pkg::cmd_e                cmd_reg;
    logic [grd_pkg::VERTEX_W-1:0] src_reg, dst_reg, start_reg;

    // adjacency storage, one row per vertex; invalid rows read as zero
    logic [NUM_VERTICES-1:0]      adj_mem [NUM_VERTICES];
    logic [NUM_VERTICES-1:0]      row_valid_reg;
    logic [NUM_VERTICES-1:0]      rd_data_reg;
    logic                         rd_valid_reg;

    logic [NUM_VERTICES-1:0]      visited_reg, pending_reg;
    logic [grd_pkg::COUNT_W-1:0]  walk_count_reg;

    logic                         out_valid_reg, out_bad_reg;
    logic [grd_pkg::MASK_W-1:0]   out_mask_reg;
    logic [grd_pkg::COUNT_W-1:0]  out_count_reg;

    logic [VIDX_W-1:0]            pick_idx, addr, other_idx;
    logic [NUM_VERTICES-1:0]      row, wr_row, limit, fresh;
    logic                         edge_bad, start_bad, item_bad;

    always_comb begin
        for (int i = 0; i < NUM_VERTICES; i++) begin
            limit[i] = (grd_pkg::COUNT_W'(i) < n_eff);
        end
    end

    assign pick_idx = lowest_set(pending_reg);

    always_comb begin
        unique case (cmd.addr_sel)
            grd_pkg::SEL_SRC:  addr = src_reg[VIDX_W-1:0];
            grd_pkg::SEL_DST:  addr = dst_reg[VIDX_W-1:0];
            grd_pkg::SEL_PICK: addr = pick_idx;
            default:           addr = pick_idx;
        endcase
    end

    assign other_idx = (cmd.addr_sel == grd_pkg::SEL_SRC) ? dst_reg[VIDX_W-1:0]
                                                          : src_reg[VIDX_W-1:0];
    assign row    = rd_valid_reg ? rd_data_reg : '0;
    assign wr_row = row | (NUM_VERTICES'(1) << other_idx);
    assign fresh  = row & limit & ~visited_reg;

    assign edge_bad  = ({1'b0, src_reg} >= n_eff) || ({1'b0, dst_reg} >= n_eff);
    assign start_bad = ({1'b0, start_reg} >= n_eff);
    assign item_bad  = (cmd_reg == grd_pkg::CMD_ADD_EDGE) ? edge_bad : start_bad;

    assign status.cmd_code      = cmd_reg;
    assign status.item_bad      = item_bad;
    assign status.pending_empty = (pending_reg == '0);
    assign status.out_free      = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg   <= grd_pkg::cmd_e'(in_cmd);
            src_reg   <= in_src;
            dst_reg   <= in_dst;
            start_reg <= in_start;
        end
    end

    // row memory
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            adj_mem[addr] <= wr_row;
        end
        if (cmd.rd_en) begin
            rd_data_reg  <= adj_mem[addr];
            rd_valid_reg <= row_valid_reg[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (cmd.clear_rows) begin
            row_valid_reg <= '0;
        end else if (cmd.wr_en) begin
            row_valid_reg[addr] <= 1'b1;
        end
    end

    // walk state: pending holds visited vertices whose row is not yet expanded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg    <= '0;
            pending_reg    <= '0;
            walk_count_reg <= '0;
        end else if (cmd.walk_init) begin
            visited_reg    <= NUM_VERTICES'(1) << start_reg[VIDX_W-1:0];
            pending_reg    <= NUM_VERTICES'(1) << start_reg[VIDX_W-1:0];
            walk_count_reg <= '0;
        end else if (cmd.walk_issue) begin
            pending_reg[pick_idx] <= 1'b0;
            walk_count_reg        <= walk_count_reg + 1'b1;
        end else if (cmd.walk_merge) begin
            visited_reg <= visited_reg | fresh;
            pending_reg <= pending_reg | fresh;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            out_bad_reg   <= item_bad;
            out_mask_reg  <= item_bad ? '0 : grd_pkg::MASK_W'(visited_reg);
            out_count_reg <= item_bad ? '0 : walk_count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_mask  = out_mask_reg;
    assign out_count = out_count_reg;
    assign out_bad   = out_bad_reg;

    `ASSERT_ALWAYS(a_pending_in_visited, aclk, aresetn, (pending_reg & ~visited_reg) == '0)
    `ASSERT_ALWAYS(a_count_bounded, aclk, aresetn, walk_count_reg <= grd_pkg::COUNT_W'(NUM_VERTICES))
    `ASSERT_IMPLIES(a_issue_nonempty, aclk, aresetn, cmd.walk_issue, pending_reg != '0)

endmodule
